// File: hw/rtl/ovb_pkg.sv
package ovb_pkg;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BLEND = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } ovb_op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_OPACITY = 2'd2;

  localparam int DEF_MAX_PIXELS = 131072;
  localparam int DEF_MAX_SIDE   = 2048;

  localparam int SIDE_W = 13;
  localparam int IDX_W  = 26;

  // Component divider sizes.
  localparam int DIV_NW = 41;
  localparam int DIV_QW = 17;
  localparam int DIV_CW = 5;
  localparam logic [DIV_CW-1:0] MIX_STEPS = 5'd9;

  // Source alpha: (t * 65536 + D/2) / D with D = 255 * 255 * 256 equals
  // (t * 512 + 65025) / 130050. The quotient is estimated with a reciprocal
  // of 2^33 / 130050 and then raised by one when the remainder allows.
  localparam int SA_NW = 33;
  localparam logic [SA_NW-1:0] SA_BIAS  = 33'd65025;
  localparam logic [SA_NW-1:0] SA_DIV   = 33'd130050;
  localparam logic [16:0]      SA_RECIP = 17'd66051;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_FETCH,
    ST_SA_MUL,
    ST_SA_REM,
    ST_SA_FIX,
    ST_COVER,
    ST_MULA,
    ST_MULB,
    ST_MIX_GO,
    ST_MIX_WAIT,
    ST_WRITE,
    ST_DONE
  } ovb_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] steps;
    logic [DIV_NW-1:0] num;
    logic [DIV_NW-1:0] dsh;
  } div_req_t;

endpackage

// File: hw/rtl/yuv_overlay_alpha_blend_unit.sv
// Subtitle overlay store with "over" blending. Each input beat carries an
// operation in s_tuser (clear, blend, read) and a pixel position with an RGB
// colour, coverage and transparency in s_tdata; each input gives exactly one
// output beat with the pixel after the operation, or all zeros with the
// accepted flag low when the position is outside the overlay, the operation
// code is unknown, or a blend has zero source alpha. Items are processed one
// at a time: a new beat is accepted only after the last item's result has
// been loaded into the output register. The source alpha comes from a
// reciprocal multiply with one correction step; each of the three blended
// components is formed by the bit-serial divider in 9 steps. A stalled
// output beat holds the block in its done state until the beat is taken.
// The pixel state lives in one 32-bit-wide synchronous memory of MAX_PIXELS
// words; an entry must be cleared before it is read or blended.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while the block is idle, which the block itself does not enforce.
module yuv_overlay_alpha_blend_unit #(
  parameter int MAX_PIXELS = ovb_pkg::DEF_MAX_PIXELS,
  parameter int MAX_SIDE   = ovb_pkg::DEF_MAX_SIDE
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // Input beats.
  input  logic        s_tvalid,
  output logic        s_tready,
  // pos_x[12:0], pos_y[25:13], red[33:26], green[41:34], blue[49:42],
  // coverage[57:50], transparency[65:58], zero fill above.
  input  logic [71:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]  s_tuser,
  // Result beats.
  output logic        m_tvalid,
  input  logic        m_tready,
  // alpha_out[7:0], luma_out[15:8], chroma_u_out[23:16], chroma_v_out[31:24]
  output logic [31:0] m_tdata,
  // accepted[0]
  output logic        m_tuser
);
  import ovb_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  // Configuration registers.
  logic [11:0] overlay_width;
  logic [11:0] overlay_height;
  logic [8:0]  opacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_width  <= '0;
      overlay_height <= '0;
      opacity        <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:   overlay_width  <= cfg_data;
        REG_HEIGHT:  overlay_height <= cfg_data;
        REG_OPACITY: opacity        <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  ovb_state_t state, state_next;

  // Latched item.
  ovb_op_t           op;
  logic [SIDE_W-1:0] pos_x, pos_y;
  logic [7:0]        red, green, blue, coverage, transparency;

  // Working registers.
  logic [IDX_W-1:0]  idx;
  logic [15:0]       tprod1;
  logic [24:0]       tprod2;
  logic [7:0]        ys, us, vs;
  logic [7:0]        da, dy, du, dv;
  logic [16:0]       sa, inv;
  logic [16:0]       sa_est;
  logic [17:0]       sa_rem;
  logic [23:0]       s_tot;
  logic [7:0]        alpha_new;
  logic [24:0]       ma;
  logic [15:0]       mb;
  logic [32:0]       num;
  logic [1:0]        comp;
  logic [7:0]        ry, ru, rv;
  logic              acc;

  // Effective geometry, saturated to the maximum side.
  logic [SIDE_W-1:0] w_eff, h_eff;
  logic [IDX_W-1:0]  idx_c;
  logic              inside_c;
  logic [8:0]        opq;

  assign w_eff = ({1'b0, overlay_width} > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                             : {1'b0, overlay_width};
  assign h_eff = ({1'b0, overlay_height} > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                              : {1'b0, overlay_height};
  assign idx_c = IDX_W'(pos_y[11:0] * w_eff) + IDX_W'(pos_x[11:0]);
  assign inside_c = !pos_x[SIDE_W-1] && !pos_y[SIDE_W-1] && (pos_x < w_eff) &&
                    (pos_y < h_eff) && (idx_c < IDX_W'(MAX_PIXELS));
  assign opq = (opacity > 9'd256) ? 9'd256 : opacity;

  // Colour conversion; the U and V sums never go negative.
  logic [25:0] y_sum, u_sum, v_sum;
  assign y_sum = 26'(19595 * red) + 26'(38470 * green) + 26'(7471 * blue);
  assign u_sum = 26'd8388608 + 26'({blue, 15'b0}) - 26'(11058 * red) - 26'(21710 * green);
  assign v_sum = 26'd8388608 + 26'({red, 15'b0}) - 26'(27439 * green) - 26'(5329 * blue);

  // Source alpha. The reciprocal estimate is low by at most one, so a single
  // compare of the remainder against the divisor completes the quotient.
  logic [SA_NW-1:0] sa_num;
  logic [49:0]      sa_prod;
  logic [16:0]      sa_fix;

  assign sa_num  = SA_NW'({tprod2, 9'b0}) + SA_BIAS;
  assign sa_prod = 50'(sa_num) * 50'(SA_RECIP);
  assign sa_fix  = sa_est + 17'(sa_rem >= 18'(SA_DIV));

  // Memory.
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_rdata;

  assign mem_we   = (state == ST_WRITE);
  assign mem_addr = (state == ST_WRITE) ? idx[AW-1:0] : idx_c[AW-1:0];

  ovb_mem #(.DEPTH(MAX_PIXELS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ({rv, ru, ry, alpha_new}),
    .rdata (mem_rdata)
  );

  // Divider.
  div_req_t          dreq;
  logic              ddone;
  logic [DIV_QW-1:0] dquo;

  ovb_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quo  (dquo)
  );

  // Blend arithmetic helpers.
  logic [7:0]  src_c, dst_c;
  logic [24:0] s_round;
  logic [25:0] s_sum;
  logic [7:0]  mix_c;

  always_comb begin
    case (comp)
      2'd0:    begin src_c = ys; dst_c = dy; end
      2'd1:    begin src_c = us; dst_c = du; end
      default: begin src_c = vs; dst_c = dv; end
    endcase
  end

  assign s_sum   = 26'({sa, 8'b0} - 25'(sa)) + 26'(da * inv);
  assign s_round = 25'(s_sum[23:0]) + 25'd32768;
  assign mix_c   = (dquo > DIV_QW'(255)) ? 8'd255 : dquo[7:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_ADDR;
      ST_ADDR: begin
        if (!inside_c || op == OP_NONE) state_next = ST_DONE;
        else if (op == OP_CLEAR)        state_next = ST_WRITE;
        else                            state_next = ST_FETCH;
      end
      ST_FETCH:    state_next = (op == OP_READ) ? ST_DONE : ST_SA_MUL;
      ST_SA_MUL:   state_next = ST_SA_REM;
      ST_SA_REM:   state_next = ST_SA_FIX;
      ST_SA_FIX:   state_next = (sa_fix == '0) ? ST_DONE : ST_COVER;
      ST_COVER:    state_next = ST_MULA;
      ST_MULA:     state_next = ST_MULB;
      ST_MULB:     state_next = ST_MIX_GO;
      ST_MIX_GO:   state_next = ST_MIX_WAIT;
      ST_MIX_WAIT: begin
        if (ddone) state_next = (comp == 2'd2) ? ST_WRITE : ST_MULA;
      end
      ST_WRITE:    state_next = ST_DONE;
      ST_DONE:     if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_tready   = 1'b0;
    dreq.start = 1'b0;
    dreq.steps = MIX_STEPS;
    dreq.num   = DIV_NW'({num, 1'b0}) + DIV_NW'(s_tot);
    dreq.dsh   = DIV_NW'({s_tot, 9'b0});
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_MIX_GO: dreq.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op           <= ovb_op_t'(s_tuser);
        pos_x        <= s_tdata[12:0];
        pos_y        <= s_tdata[25:13];
        red          <= s_tdata[33:26];
        green        <= s_tdata[41:34];
        blue         <= s_tdata[49:42];
        coverage     <= s_tdata[57:50];
        transparency <= s_tdata[65:58];
        acc          <= 1'b0;
      end
      ST_ADDR: begin
        idx    <= idx_c;
        tprod1 <= (8'd255 - transparency) * coverage;
        if (inside_c && op == OP_CLEAR) begin
          alpha_new <= 8'd0;
          ry        <= 8'd0;
          ru        <= 8'd128;
          rv        <= 8'd128;
          acc       <= 1'b1;
        end
      end
      ST_FETCH: begin
        da     <= mem_rdata[7:0];
        dy     <= mem_rdata[15:8];
        du     <= mem_rdata[23:16];
        dv     <= mem_rdata[31:24];
        tprod2 <= 25'(tprod1 * opq);
        ys     <= y_sum[23:16];
        us     <= u_sum[23:16];
        vs     <= v_sum[23:16];
        if (op == OP_READ) begin
          alpha_new <= mem_rdata[7:0];
          ry        <= mem_rdata[15:8];
          ru        <= mem_rdata[23:16];
          rv        <= mem_rdata[31:24];
          acc       <= 1'b1;
        end
      end
      ST_SA_MUL: begin
        sa_est <= sa_prod[49:33];
      end
      ST_SA_REM: begin
        sa_rem <= 18'(sa_num - SA_NW'(sa_est * SA_DIV));
      end
      ST_SA_FIX: begin
        sa  <= sa_fix;
        inv <= 17'd65536 - sa_fix;
      end
      ST_COVER: begin
        s_tot     <= s_sum[23:0];
        alpha_new <= (s_round[24:16] > 9'd255) ? 8'd255 : s_round[23:16];
        comp      <= 2'd0;
      end
      ST_MULA: begin
        ma <= 25'(src_c * sa);
        mb <= dst_c * da;
      end
      ST_MULB: begin
        num <= 33'({ma, 8'b0} - 33'(ma)) + 33'(mb * inv);
      end
      ST_MIX_WAIT: begin
        if (ddone) begin
          case (comp)
            2'd0:    ry <= mix_c;
            2'd1:    ru <= mix_c;
            default: rv <= mix_c;
          endcase
          comp <= comp + 2'd1;
        end
      end
      ST_WRITE: begin
        acc <= 1'b1;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tuser <= acc;
          m_tdata <= acc ? {rv, ru, ry, alpha_new} : 32'd0;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/ovb_mem.sv
module ovb_mem #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hw/rtl/ovb_div.sv
module ovb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  ovb_pkg::div_req_t           req,
  output logic                        done,
  output logic [ovb_pkg::DIV_QW-1:0]  quo
);
  import ovb_pkg::*;

  logic [DIV_NW-1:0] rem;
  logic [DIV_NW-1:0] dsh;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic              fit;

  // Restoring division, one quotient bit per cycle, divisor pre-shifted.
  assign fit = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      dsh <= req.dsh;
      cnt <= req.steps;
      quo <= '0;
    end else if (busy) begin
      if (fit) begin
        rem <= rem - dsh;
      end
      quo <= {quo[DIV_QW-2:0], fit};
      dsh <= dsh >> 1;
      cnt <= cnt - DIV_CW'(1);
    end
  end

endmodule
